// ----- rtl/e2cal_pkg.sv -----
// Package for the epoch seconds to calendar converter.
// Holds the channel item types, calendar constants and the month table.
// No dependencies.
`default_nettype none

package e2cal_pkg;

    typedef struct packed {
        logic [31:0] whole_seconds;
        logic [31:0] second_fraction;
    } t_in_item;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [31:0] fraction_out;
    } t_out_item;

    localparam logic [31:0] LastSecond   = 32'd4102444799;
    localparam logic [16:0] SecsPerDay   = 17'd86400;
    localparam logic [10:0] DaysPerCycle = 11'd1461;
    localparam logic [11:0] SecsPerHour  = 12'd3600;
    localparam logic [5:0]  SecsPerMin   = 6'd60;
    localparam logic [11:0] BaseYear     = 12'd1970;
    localparam logic [5:0]  LastMonth    = 6'd47;   // last entry of the 48-month cycle

    // Quotient widths of the restoring divisions
    localparam int DayQBits  = 16;  // days since epoch, < 47483
    localparam int CycQBits  = 6;   // four-year cycles, <= 32
    localparam int HourQBits = 5;   // hours, < 24
    localparam int MinQBits  = 6;   // minutes, < 60

    // Year within the four-year cycle for a month index 0..47
    function automatic logic [1:0] year_in_cycle(input logic [5:0] mon);
        logic [1:0] yr;
        if (mon >= 6'd36) begin
            yr = 2'd3;
        end else if (mon >= 6'd24) begin
            yr = 2'd2;
        end else if (mon >= 6'd12) begin
            yr = 2'd1;
        end else begin
            yr = 2'd0;
        end
        return yr;
    endfunction

    // Month of year (0 = January) for a month index 0..47
    function automatic logic [3:0] month_in_year(input logic [5:0] mon);
        logic [5:0] m;
        m = mon - 6'(6'd12 * {4'b0, year_in_cycle(mon)});
        return m[3:0];
    endfunction

    // Month length table; third year of the cycle is the leap year
    function automatic logic [4:0] month_len(input logic [5:0] mon);
        logic [4:0] len;
        case (month_in_year(mon)) inside
            4'd1: begin
                len = (year_in_cycle(mon) == 2'd2) ? 5'd29 : 5'd28;
            end
            4'd3, 4'd5, 4'd8, 4'd10: begin
                len = 5'd30;
            end
            default: begin
                len = 5'd31;
            end
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/epoch_seconds_to_calendar_unit.sv -----
// Converts seconds since 1970-01-01 00:00:00 plus a 32-bit binary fraction
// into year, month, day, hour, minute and second; the fraction passes through.
// One item is in work at a time. The conversion runs in steps, where k (0..47) is
// the month index within the four-year cycle: 16 steps for the day split, 6 for
// the cycle split, k + 1 for the month walk, 5 for hours, 6 for minutes and one
// to load the output register. All division and walk steps go through a single
// 32-bit subtract-and-compare unit. The result waits in the output register; a
// new item is taken once the unit has handed its result over. Seconds past
// 2099-12-31 23:59:59 are clamped to that second.
// Depends on e2cal_pkg.
`default_nettype none

module epoch_seconds_to_calendar_unit (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  e2cal_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output e2cal_pkg::t_out_item o_out_item
);
    import e2cal_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DAYS,
        S_CYCLE,
        S_WALK,
        S_HOUR,
        S_MIN,
        S_OUT
    } t_state;

    localparam logic [31:0] DayDen  = 32'({15'b0, SecsPerDay} << (DayQBits - 1));
    localparam logic [31:0] CycDen  = 32'({21'b0, DaysPerCycle} << (CycQBits - 1));
    localparam logic [31:0] HourDen = 32'({20'b0, SecsPerHour} << (HourQBits - 1));
    localparam logic [31:0] MinDen  = 32'({26'b0, SecsPerMin} << (MinQBits - 1));

    t_state      r_state;
    logic [31:0] r_acc;
    logic [31:0] r_den;
    logic [15:0] r_q;
    logic [3:0]  r_cnt;
    logic [16:0] r_tod;
    logic [5:0]  r_cycle;
    logic [5:0]  r_mon;
    logic [4:0]  r_day;
    logic [4:0]  r_hour;
    logic [5:0]  r_minute;
    logic [5:0]  r_second;
    logic [31:0] r_frac;
    logic        r_out_valid;
    t_out_item   r_out;

    logic [31:0] sub_b;
    logic [32:0] diff;
    logic        ge;
    logic [31:0] step_acc;
    logic [15:0] step_q;
    logic        last_step;
    logic        in_fire;

    // Shared subtract/compare unit
    always_comb begin
        sub_b     = (r_state == S_WALK) ? {27'b0, month_len(r_mon)} : r_den;
        diff      = {1'b0, r_acc} - {1'b0, sub_b};
        ge        = ~diff[32];
        step_acc  = ge ? diff[31:0] : r_acc;
        step_q    = {r_q[14:0], ge};
        last_step = (r_cnt == 4'd0);
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid & o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_acc   <= (i_in_item.whole_seconds > LastSecond) ?
                                   LastSecond : i_in_item.whole_seconds;
                        r_frac  <= i_in_item.second_fraction;
                        r_den   <= DayDen;
                        r_q     <= '0;
                        r_cnt   <= 4'(DayQBits - 1);
                        r_state <= S_DAYS;
                    end
                end
                S_DAYS: begin
                    r_acc <= step_acc;
                    r_q   <= step_q;
                    r_den <= r_den >> 1;
                    r_cnt <= r_cnt - 4'd1;
                    if (last_step) begin
                        // remainder is the second of day, quotient the day count
                        r_tod   <= step_acc[16:0];
                        r_acc   <= {16'b0, step_q};
                        r_den   <= CycDen;
                        r_q     <= '0;
                        r_cnt   <= 4'(CycQBits - 1);
                        r_state <= S_CYCLE;
                    end
                end
                S_CYCLE: begin
                    r_acc <= step_acc;
                    r_q   <= step_q;
                    r_den <= r_den >> 1;
                    r_cnt <= r_cnt - 4'd1;
                    if (last_step) begin
                        r_cycle <= step_q[5:0];
                        r_mon   <= '0;
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (ge && r_mon != LastMonth) begin
                        r_acc <= diff[31:0];
                        r_mon <= r_mon + 6'd1;
                    end else begin
                        r_day   <= r_acc[4:0];
                        r_acc   <= {15'b0, r_tod};
                        r_den   <= HourDen;
                        r_q     <= '0;
                        r_cnt   <= 4'(HourQBits - 1);
                        r_state <= S_HOUR;
                    end
                end
                S_HOUR: begin
                    r_acc <= step_acc;
                    r_q   <= step_q;
                    r_den <= r_den >> 1;
                    r_cnt <= r_cnt - 4'd1;
                    if (last_step) begin
                        r_hour  <= step_q[4:0];
                        r_den   <= MinDen;
                        r_q     <= '0;
                        r_cnt   <= 4'(MinQBits - 1);
                        r_state <= S_MIN;
                    end
                end
                S_MIN: begin
                    r_acc <= step_acc;
                    r_q   <= step_q;
                    r_den <= r_den >> 1;
                    r_cnt <= r_cnt - 4'd1;
                    if (last_step) begin
                        r_minute <= step_q[5:0];
                        r_second <= step_acc[5:0];
                        r_state  <= S_OUT;
                    end
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (!r_out_valid || i_out_ready) begin
                        r_out.year         <= BaseYear + {4'b0, r_cycle, 2'b00}
                                              + {10'b0, year_in_cycle(r_mon)};
                        r_out.month        <= month_in_year(r_mon) + 4'd1;
                        r_out.day_of_month <= r_day + 5'd1;
                        r_out.hour         <= r_hour;
                        r_out.minute       <= r_minute;
                        r_out.second       <= r_second;
                        r_out.fraction_out <= r_frac;
                        r_out_valid        <= 1'b1;
                        r_state            <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_start_days: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == S_DAYS) && (r_cnt == 4'(DayQBits - 1)))
        else $error("item accepted but day split not started");

    a_walk_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_acc < 32'd1461) && (r_mon <= LastMonth))
        else $error("month walk out of range");

    a_minute_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MIN) |-> (r_acc < 32'd3600))
        else $error("minute split remainder too large");

    a_valid_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_OUT))
        else $error("result presented without finishing conversion");

    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.month >= 4'd1) && (o_out_item.month <= 4'd12)
                        && (o_out_item.day_of_month != 5'd0)
                        && (o_out_item.hour < 5'd24) && (o_out_item.minute < 6'd60)
                        && (o_out_item.second < 6'd60))
        else $error("result field out of range");

endmodule

`default_nettype wire

// ----- sim/tb_epoch_seconds_to_calendar_unit.sv -----
// Testbench for epoch_seconds_to_calendar_unit: directed and random epoch values
// are checked against a calendar predictor through a small scoreboard class.
// Depends on e2cal_pkg and the unit itself.
`timescale 1ns / 100ps

module tb_epoch_seconds_to_calendar_unit;
    import e2cal_pkg::*;

    localparam logic [31:0] SECS_PER_DAY   = 32'd86400;
    localparam logic [31:0] LAST_SECOND    = 32'd4102444799;
    localparam int unsigned DAYS_PER_CYCLE = 1461;
    localparam int unsigned LAST_DAY       = 47481;     // 2099-12-31
    localparam int unsigned ITEMS_PER_PHASE = 600;
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned DRAIN_CYCLES   = 100;
    localparam int unsigned CYCLE_LIMIT    = 1500000;

    localparam int TX_IDLE_PCT [3] = '{29, 69, 0};
    localparam int RX_IDLE_PCT [3] = '{69, 29, 0};

    localparam int unsigned N_DIRECTED = 22;
    localparam logic [31:0] DIR_SECS [N_DIRECTED] = '{
        32'd0,
        32'd86399,
        32'd86400,
        32'd59 * SECS_PER_DAY - 32'd1,        // last second of Feb 1970
        32'd59 * SECS_PER_DAY,
        32'd365 * SECS_PER_DAY - 32'd1,
        32'd365 * SECS_PER_DAY,
        32'd789 * SECS_PER_DAY + 32'd43210,   // leap day 1972
        32'd790 * SECS_PER_DAY,
        32'd1096 * SECS_PER_DAY - 32'd1,
        32'd1461 * SECS_PER_DAY - 32'd1,      // end of first four-year cycle
        32'd1461 * SECS_PER_DAY,
        32'd10957 * SECS_PER_DAY + 32'd3599,
        32'd10957 * SECS_PER_DAY + 32'd3600,
        32'd11016 * SECS_PER_DAY + 32'd59,    // leap day 2000
        32'd11016 * SECS_PER_DAY + 32'd60,
        32'h7FFF_FFFF,
        32'h8000_0000,
        32'd4102444799,
        32'd4102444800,                       // first clamped value
        32'hFFFF_FFFF,
        32'd46752 * SECS_PER_DAY              // start of last cycle, 2098
    };
    localparam logic [31:0] DIR_FRAC [6] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
        32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555
    };

    class calendar_scoreboard;
        t_out_item   pending_dates[$];
        int unsigned failures;

        function new();
            failures = 0;
        endfunction

        static function int unsigned month_days(int unsigned k);
            int unsigned len;
            case (k % 12)
                1: begin
                    len = (k / 12 == 2) ? 29 : 28;
                end
                3, 5, 8, 10: begin
                    len = 30;
                end
                default: begin
                    len = 31;
                end
            endcase
            return len;
        endfunction

        static function string fmt_date(t_out_item d);
            return $sformatf("%0d-%0d-%0d %0d:%0d:%0d frac %h", d.year, d.month,
                             d.day_of_month, d.hour, d.minute, d.second, d.fraction_out);
        endfunction

        function t_out_item to_calendar(t_in_item it);
            t_out_item   r;
            logic [31:0] secs;
            int unsigned days, tod, cyc, rem, k;
            secs = (it.whole_seconds > LAST_SECOND) ? LAST_SECOND : it.whole_seconds;
            days = secs / SECS_PER_DAY;
            tod  = secs % SECS_PER_DAY;
            cyc  = days / DAYS_PER_CYCLE;
            rem  = days % DAYS_PER_CYCLE;
            k    = 0;
            while (k < 47 && rem >= month_days(k)) begin
                rem -= month_days(k);
                k++;
            end
            r.year         = 12'(1970 + cyc * 4 + k / 12);
            r.month        = 4'(k % 12 + 1);
            r.day_of_month = 5'(rem + 1);
            r.hour         = 5'(tod / 3600);
            r.minute       = 6'((tod % 3600) / 60);
            r.second       = 6'(tod % 60);
            r.fraction_out = it.second_fraction;
            return r;
        endfunction

        function void note_input(t_in_item it);
            pending_dates.push_back(to_calendar(it));
        endfunction

        function void check_result(t_out_item got);
            t_out_item exp_date;
            if (pending_dates.size() == 0) begin
                failures++;
                if (failures <= 10) begin
                    $display("unexpected date item: %s", fmt_date(got));
                end
                return;
            end
            exp_date = pending_dates.pop_front();
            if (got.year != exp_date.year || got.month != exp_date.month ||
                got.day_of_month != exp_date.day_of_month || got.hour != exp_date.hour ||
                got.minute != exp_date.minute || got.second != exp_date.second ||
                got.fraction_out != exp_date.fraction_out) begin
                failures++;
                if (failures <= 10) begin
                    $display("date mismatch: expected %s, got %s",
                             fmt_date(exp_date), fmt_date(got));
                end
            end
        endfunction

        function int unsigned pending();
            return pending_dates.size();
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;

    calendar_scoreboard sb = new();
    int          tx_idle_pct;
    int          rx_idle_pct;
    bit          hold_req;
    int unsigned cycle_count;

    epoch_seconds_to_calendar_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Random epoch: full range, clamp region, month edges, or any valid day
    function automatic t_in_item random_epoch();
        t_in_item    it;
        int unsigned day, tod, k;
        tod = $urandom_range(0, 86399);
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                it.whole_seconds = $urandom;
            end
            3: begin
                it.whole_seconds = $urandom_range(32'hFFFF_FFFF, 32'd4102444800);
            end
            4, 5: begin
                k   = $urandom_range(0, 47);
                day = $urandom_range(0, 32) * DAYS_PER_CYCLE;
                for (int m = 0; m < k; m++) begin
                    day += calendar_scoreboard::month_days(m);
                end
                if ($urandom_range(0, 1) && day > 0) begin
                    day -= 1;
                    tod = 86399 - $urandom_range(0, 2);
                end else begin
                    tod = $urandom_range(0, 2);
                end
                if (day > LAST_DAY) begin
                    day = LAST_DAY;
                end
                it.whole_seconds = day * SECS_PER_DAY + tod;
            end
            default: begin
                day = $urandom_range(0, LAST_DAY);
                it.whole_seconds = day * SECS_PER_DAY + tod;
            end
        endcase
        case ($urandom_range(0, 7))
            0: begin
                it.second_fraction = 32'h0;
            end
            1: begin
                it.second_fraction = 32'hFFFF_FFFF;
            end
            default: begin
                it.second_fraction = $urandom;
            end
        endcase
        return it;
    endfunction

    // Offer one item after a random gap and wait for its handshake
    task automatic offer_epoch(t_in_item it);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        sb.note_input(it);
    endtask

    task automatic wait_until_drained();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_out_item);
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_epoch_seconds_to_calendar_unit failed");
        $finish;
    end

    initial begin
        t_in_item it;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req    = 1'b0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_item  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            it.whole_seconds   = DIR_SECS[i];
            it.second_fraction = DIR_FRAC[i % 6];
            offer_epoch(it);
        end
        wait_until_drained();

        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = TX_IDLE_PCT[phase];
            rx_idle_pct = RX_IDLE_PCT[phase];
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // long output stall while items keep coming: input must back up
                if (phase == 2 && n == 200) begin
                    hold_req = 1'b1;
                end
                offer_epoch(random_epoch());
            end
            wait_until_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("tb_epoch_seconds_to_calendar_unit passed");
        end else begin
            $display("tb_epoch_seconds_to_calendar_unit failed");
        end
        $finish;
    end

endmodule
